// File: hdl/elfh_pkg.sv
// Shared types and constants for the ELF string hash block.
// No dependencies; every module of the block imports this package.
package elfh_pkg;

	localparam int HASH_W = 28;
	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int STEP_W = $clog2(HASH_W + 1);
	localparam logic [WORD_W-1:0] BUCKET_RESET = 32'd1024;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic  vld;
		hash_t hash;
	} q_wr_t;

	typedef struct packed {
		logic  vld;
		hash_t hash;
	} q_rd_t;

	function automatic hash_t hash_update(hash_t h, byte_t b);
		logic [WORD_W-1:0] sum;
		sum = {h, 4'b0000} + {{(WORD_W - BYTE_W){b[BYTE_W-1]}}, b};
		return sum[HASH_W-1:0] ^ {{(HASH_W - 8){1'b0}}, sum[WORD_W-1:HASH_W], 4'b0000};
	endfunction

endpackage

// File: hdl/elfh_front.sv
// Front end: accepts key bytes, keeps the running hash and queues finished hashes.
// Depends on elfh_pkg.
module elfh_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  elfh_pkg::byte_t key_byte,
	input  logic           q_full,
	output elfh_pkg::q_wr_t q_wr
);
	import elfh_pkg::*;

	hash_t hash_q;
	logic  accept;
	logic  key_end;

	assign key_end  = (key_byte == '0);
	assign in_stall = q_full && key_end;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			if (key_end) begin
				hash_q <= '0;
			end else begin
				hash_q <= hash_update(hash_q, key_byte);
			end
		end
	end

	assign q_wr.vld  = accept && key_end;
	assign q_wr.hash = hash_q;

endmodule

// File: hdl/elfh_queue.sv
// Short queue of finished hashes between the front end and the reduction unit.
// Depends on elfh_pkg.
module elfh_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  elfh_pkg::q_wr_t q_wr,
	output logic            q_full,
	input  logic            q_pop,
	output elfh_pkg::q_rd_t q_rd
);
	import elfh_pkg::*;

	hash_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign q_full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = q_wr.vld && !q_full;
	assign pop       = q_pop && (cnt_q != '0);
	assign q_rd.vld  = (cnt_q != '0);
	assign q_rd.hash = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= q_wr.hash;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.vld |-> !q_full)
		else $error("finished hash pushed into a full queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

// File: hdl/elfh_reduce.sv
// Back end: bit-serial restoring remainder of the hash by the bucket count,
// with an output register toward the result channel. Depends on elfh_pkg.
module elfh_reduce (
	input  logic            clk,
	input  logic            arst_n,
	input  elfh_pkg::word_t bucket_count,
	input  elfh_pkg::q_rd_t q_rd,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output elfh_pkg::word_t bucket_index,
	output elfh_pkg::hash_t raw_hash
);
	import elfh_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DIV  = 2'b10
	} state_t;

	state_t            state_q;
	hash_t             hash_q;
	hash_t             dvd_q;
	hash_t             rem_q;
	word_t             div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;
	word_t             index_q;
	hash_t             raw_q;
	logic [HASH_W:0]   trial;
	word_t             diff;
	logic              fits;
	logic              steps_done;
	logic              out_free;
	logic              load;

	assign trial      = {rem_q, dvd_q[HASH_W-1]};
	assign fits       = {{(WORD_W - HASH_W - 1){1'b0}}, trial} >= div_q;
	assign diff       = {{(WORD_W - HASH_W - 1){1'b0}}, trial} - div_q;
	assign steps_done = (cnt_q == STEP_W'(HASH_W));
	assign out_free   = !out_valid_q || !out_stall;
	assign load       = (state_q == S_DIV) && steps_done && out_free;
	assign q_pop      = (state_q == S_IDLE) && q_rd.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_rd.vld) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (!steps_done) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hash_q <= q_rd.hash;
			dvd_q  <= q_rd.hash;
			rem_q  <= '0;
			div_q  <= bucket_count;
		end else if ((state_q == S_DIV) && !steps_done) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= fits ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
		end
		if (load) begin
			raw_q   <= hash_q;
			index_q <= (div_q == '0) ? {{(WORD_W - HASH_W){1'b0}}, hash_q}
			                         : {{(WORD_W - HASH_W){1'b0}}, rem_q};
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = index_q;
	assign raw_hash     = raw_q;

`ifndef SYNTH
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("computed result not presented");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= STEP_W'(HASH_W))
		else $error("division step count out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(bucket_index) && $stable(raw_hash)))
		else $error("stalled result word changed");
`endif

endmodule

// File: hdl/elf_string_hash_mod_top.sv
// Flow: an accepted terminating zero byte is queued, popped into the reduction unit, taken
// through 28 restoring division steps and loaded into the output register, waiting while
// the unit is busy or out_stall holds a result. Throughput: one key byte per cycle unless
// in_stall; the one-bit-per-cycle divider takes a new hash only when idle, behind a two-entry queue.
// Reset: arst_n clears the running hash, the queue and the result valid, and
// sets bucket_count to 1024. Depends on elfh_pkg and the elfh_* modules.
module elf_string_hash_mod_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  elfh_pkg::byte_t key_byte,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  elfh_pkg::word_t bucket_count,
	output logic            out_valid,
	input  logic            out_stall,
	output elfh_pkg::word_t bucket_index,
	output elfh_pkg::hash_t raw_hash
);
	import elfh_pkg::*;

	word_t bucket_count_q;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_q <= bucket_count;
		end
	end

	elfh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.key_byte (key_byte),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	elfh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_rd   (q_rd)
	);

	elfh_reduce u_reduce (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bucket_count_q),
		.q_rd         (q_rd),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bucket_index (bucket_index),
		.raw_hash     (raw_hash)
	);

endmodule
